### rtl/core/inverse_pair_cancel_reducer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inverse pair cancel reducer
// Clocked implication checks, reset disables them.
// ----------------------------------------------------------------------------
`ifndef INVERSE_PAIR_CANCEL_REDUCER_TOP_ASSERT_SVH
`define INVERSE_PAIR_CANCEL_REDUCER_TOP_ASSERT_SVH

// same-cycle implication
`define IPCR_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPCR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ipcr_pkg.sv
// ----------------------------------------------------------------------------
// ipcr_pkg
// Types, constants and the inverse symbol lookup of the cancel reducer.
// ----------------------------------------------------------------------------
package ipcr_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_CLOSE = 8'h5D;
  localparam logic [7:0] SYM_LT    = 8'h3C;
  localparam logic [7:0] SYM_GT    = 8'h3E;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       end_of_program;
  } item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       out_last;
    logic       result_empty;
    logic       overflowed;
  } result_t;

  typedef struct packed {
    logic       has_inv;
    logic [7:0] inv_top;
  } inv_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       end_of_program;
    logic       has_inv;
    logic [7:0] inv_top;
  } op_t;

  // stack top that an incoming symbol cancels
  function automatic inv_t inverse_of(input logic [7:0] s);
    inv_t r;
    r.has_inv = 1'b1;
    r.inv_top = 8'h00;
    unique case (s)
      SYM_MINUS: r.inv_top = SYM_PLUS;
      SYM_PLUS:  r.inv_top = SYM_MINUS;
      SYM_CLOSE: r.inv_top = SYM_OPEN;
      SYM_GT:    r.inv_top = SYM_LT;
      SYM_LT:    r.inv_top = SYM_GT;
      default:   r.has_inv = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/inverse_pair_cancel_reducer_top.sv
// ----------------------------------------------------------------------------
// inverse_pair_cancel_reducer_top
// Reduces a byte program by cancelling inverse symbol pairs on a stack.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_ready carries one program byte per
// transfer, with symbol_valid and end_of_program flags. Items with neither
// flag set are dropped. Output channel result/result_valid/result_ready
// returns the reduced program, bottom of stack first, out_last on the final
// byte; an empty program gives one transfer with result_empty set.
// Throughput: one item per cycle while the stack unit is in RUN; a cancel
// that leaves one or more entries passes through REFILL to reload the cached
// top from the stack memory. The drain after an end marker passes through
// DRAIN_RD and DRAIN, one memory read per stored entry (one read when empty).
// The first result is loaded from DRAIN after DRAIN_RD reads the bottom entry.
// A four-entry queue lets input continue while the stack unit is busy.
// A stalled receiver holds the result register and pauses the drain; input
// is taken until the queue fills. Reset empties the stack, the queue and
// the overflow flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module inverse_pair_cancel_reducer_top #(
  parameter int unsigned STACK_DEPTH = ipcr_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ipcr_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_ready,
  output ipcr_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);

  ipcr_pkg::op_t front_op;
  logic          front_valid;
  logic          front_ready;
  ipcr_pkg::op_t queue_op;
  logic          queue_valid;
  logic          queue_ready;

  ipcr_front u_front (
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (front_op),
    .op_valid   (front_valid),
    .op_ready   (front_ready)
  );

  ipcr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_op),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_data  (queue_op),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  ipcr_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op           (queue_op),
    .op_valid     (queue_valid),
    .op_ready     (queue_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

### rtl/core/ipcr_front.sv
// ----------------------------------------------------------------------------
// ipcr_front
// Accepts input items, drops empty ones and tags each symbol with its inverse.
// ----------------------------------------------------------------------------
module ipcr_front (
  input  ipcr_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_ready,
  output ipcr_pkg::op_t   op,
  output logic            op_valid,
  input  logic            op_ready
);

  ipcr_pkg::inv_t inv;

  assign inv = ipcr_pkg::inverse_of(item.symbol);

  assign item_ready = op_ready;
  assign op_valid   = item_valid && (item.symbol_valid || item.end_of_program);

  always_comb begin
    op.symbol         = item.symbol;
    op.symbol_valid   = item.symbol_valid;
    op.end_of_program = item.end_of_program;
    op.has_inv        = inv.has_inv;
    op.inv_top        = inv.inv_top;
  end

endmodule

### rtl/core/ipcr_fifo.sv
// ----------------------------------------------------------------------------
// ipcr_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ipcr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  ipcr_pkg::op_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output ipcr_pkg::op_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);

  localparam int unsigned DEPTH = ipcr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ipcr_pkg::op_t    entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != CNT_W'(DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/ipcr_back.sv
// ----------------------------------------------------------------------------
// ipcr_back
// Symbol stack with cached top, cancel, push or overflow per symbol, drain on end marker.
// ----------------------------------------------------------------------------
`include "inverse_pair_cancel_reducer_top_assert.svh"

module ipcr_back #(
  parameter int unsigned STACK_DEPTH = ipcr_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ipcr_pkg::op_t     op,
  input  logic              op_valid,
  output logic              op_ready,
  output ipcr_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

  typedef enum logic [3:0] {
    RUN      = 4'b0001,
    REFILL   = 4'b0010,
    DRAIN_RD = 4'b0100,
    DRAIN    = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              ovf, ovf_next;
  logic [7:0]        top, top_next;
  logic [IDX_W-1:0]  idx, idx_next;

  logic [7:0]        mem [STACK_DEPTH];
  logic [7:0]        rdata;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;

  logic              do_cancel;
  logic              do_push;
  logic              set_ovf;
  logic              out_free;
  logic              at_last;
  logic              load;
  ipcr_pkg::result_t load_data;

  assign do_cancel = op.symbol_valid && op.has_inv && (count != '0) && (top == op.inv_top);
  assign do_push   = op.symbol_valid && !do_cancel && (count != FULL);
  assign set_ovf   = op.symbol_valid && !do_cancel && (count == FULL);
  assign out_free  = !result_valid || result_ready;
  assign at_last   = (CNT_W'(idx) + CNT_W'(1)) == count;

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    top_next   = top;
    idx_next   = idx;
    we         = 1'b0;
    waddr      = IDX_W'(count);
    re         = 1'b0;
    raddr      = idx;
    op_ready   = 1'b0;
    load       = 1'b0;
    load_data  = '0;
    unique case (state)
      RUN: begin
        op_ready = 1'b1;
        if (op_valid) begin
          if (do_cancel) begin
            count_next = count - CNT_W'(1);
          end else if (do_push) begin
            we         = 1'b1;
            count_next = count + CNT_W'(1);
            top_next   = op.symbol;
          end else if (set_ovf) begin
            ovf_next = 1'b1;
          end
          if (op.end_of_program) begin
            idx_next   = '0;
            state_next = DRAIN_RD;
          end else if (do_cancel && (count > CNT_W'(1))) begin
            re         = 1'b1;
            raddr      = IDX_W'(count - CNT_W'(2));
            state_next = REFILL;
          end
        end
      end
      REFILL: begin
        top_next   = rdata;
        state_next = RUN;
      end
      DRAIN_RD: begin
        re         = 1'b1;
        state_next = DRAIN;
      end
      DRAIN: begin
        if (out_free) begin
          load                 = 1'b1;
          load_data.overflowed = ovf;
          if (count == '0) begin
            load_data.out_last     = 1'b1;
            load_data.result_empty = 1'b1;
          end else begin
            load_data.out_symbol = rdata;
            load_data.out_last   = at_last;
          end
          if ((count == '0) || at_last) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = RUN;
          end else begin
            idx_next = idx + IDX_W'(1);
            re       = 1'b1;
            raddr    = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= op.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= RUN;
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    idx <= idx_next;
    if (load) begin
      result <= load_data;
    end
  end

  `IPCR_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= FULL, "stack count beyond depth")
  `IPCR_ASSERT_NEXT(a_drain_clears, clk, rst, load && load_data.out_last, count == '0 && !ovf && state == RUN, "drain end did not clear stack")
  `IPCR_ASSERT_IMPL(a_ovf_when_full, clk, rst, $rose(ovf), $past(count) == FULL, "overflow set below full stack")
  `IPCR_ASSERT_IMPL(a_empty_shape, clk, rst, result_valid && result.result_empty, result.out_last && result.out_symbol == 8'h00, "malformed empty result")

endmodule
